FILE: rtl/core/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// shared types, codes and constants of the longest prefix router lookup
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int LPR_TABLE_ENTRIES = 64;
  localparam int LPR_MAX_ROUTERS   = 16;

  localparam int ADDR_W   = 32;
  localparam int ROUTER_W = 4;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 3;
  localparam int PLEN_W   = 6;
  localparam int RCOUNT_W = 5;

  localparam logic [RCOUNT_W-1:0] RCOUNT_RESET = RCOUNT_W'(16);
  localparam logic [PLEN_W-1:0]   PLEN_FULL    = PLEN_W'(ADDR_W);

  localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LPM    = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_EXACT  = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_DUPLICATE   = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND   = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_TABLE_FULL  = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_BAD_ROUTER  = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_SAME_ROUTER = 3'd5;
  localparam logic [STATUS_W-1:0] STATUS_NO_DEVICES  = 3'd6;

  typedef struct packed {
    logic                valid;
    logic [ADDR_W-1:0]   address;
    logic [ROUTER_W-1:0] owner;
  } entry_t;

  typedef struct packed {
    logic                any;
    logic [PLEN_W-1:0]   best_len;
    logic [ROUTER_W-1:0] best_owner;
    logic                exact_hit;
    logic [ROUTER_W-1:0] exact_owner;
    logic                free_hit;
  } match_t;

endpackage

FILE: rtl/core/lpr_table.sv
// ----------------------------------------------------------------------------
// lpr_table
// entry memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module lpr_table
  import lpr_pkg::*;
#(
  parameter int TABLE_ENTRIES = LPR_TABLE_ENTRIES,
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/lpr_match.sv
// ----------------------------------------------------------------------------
// lpr_match
// shared compare unit: prefix length, exact match and free slot per entry,
// folded into running best values over the scan
// ----------------------------------------------------------------------------
module lpr_match
  import lpr_pkg::*;
#(
  parameter int TABLE_ENTRIES = LPR_TABLE_ENTRIES,
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                chk_valid,
  input  logic [IW-1:0]       chk_idx,
  input  entry_t              entry,
  input  logic [ADDR_W-1:0]   key,
  input  logic [RCOUNT_W-1:0] rc,
  output match_t              result,
  output logic [IW-1:0]       exact_idx,
  output logic [IW-1:0]       free_idx
);

  logic              visible;
  logic [ADDR_W-1:0] diff;
  logic [PLEN_W-1:0] plen;
  logic              better;
  logic              exact_better;

  always_comb begin
    diff = key ^ entry.address;
    plen = PLEN_FULL;
    for (int i = 0; i < ADDR_W; i++) begin
      if (diff[i]) begin
        plen = PLEN_W'(ADDR_W - 1 - i);
      end
    end
    visible = entry.valid && ({1'b0, entry.owner} < rc);
    better = visible && (!result.any || plen > result.best_len ||
             (plen == result.best_len && entry.owner < result.best_owner));
    exact_better = visible && (entry.address == key) &&
                   (!result.exact_hit || entry.owner < result.exact_owner);
  end

  always_ff @(posedge clk) begin
    if (rst || start) begin
      result.any       <= 1'b0;
      result.exact_hit <= 1'b0;
      result.free_hit  <= 1'b0;
    end else if (chk_valid) begin
      if (better) begin
        result.any        <= 1'b1;
        result.best_len   <= plen;
        result.best_owner <= entry.owner;
      end
      if (exact_better) begin
        result.exact_hit   <= 1'b1;
        result.exact_owner <= entry.owner;
        exact_idx          <= chk_idx;
      end
      if (!entry.valid && !result.free_hit) begin
        result.free_hit <= 1'b1;
        free_idx        <= chk_idx;
      end
    end
  end

endmodule

FILE: rtl/core/longest_prefix_router_lookup.sv
// ----------------------------------------------------------------------------
// longest_prefix_router_lookup
// one beat at a time: s_tready stays low from an accepted input beat until
//   its result beat is registered, as the single table read port and the
//   one compare unit visit each entry in turn
// reset: a clearing pass writes every table entry to zero, s_tready low meanwhile
// ----------------------------------------------------------------------------
module longest_prefix_router_lookup
  import lpr_pkg::*;
#(
  parameter int TABLE_ENTRIES = LPR_TABLE_ENTRIES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [RCOUNT_W-1:0] cfg_wr_data,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [39:0]         s_tdata,  // action[1:0], address[33:2], router[37:34]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [15:0]         m_tdata   // status[2:0], found_router[6:3], prefix_length[12:7]
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_DECIDE = 2'd3;

  logic [1:0]          state;
  logic [RCOUNT_W-1:0] router_count;
  logic [RCOUNT_W-1:0] rc;
  logic [ACTION_W-1:0] op_action;
  logic [ADDR_W-1:0]   op_address;
  logic [ROUTER_W-1:0] op_router;
  logic [CW-1:0]       cnt;
  logic                chk_pending;
  logic [IW-1:0]       chk_idx;

  logic [STATUS_W-1:0] out_status;
  logic [ROUTER_W-1:0] out_router;
  logic [PLEN_W-1:0]   out_plen;

  logic                accept;
  logic                issue;
  logic                can_out;
  logic                finish;

  entry_t              rd_data;
  match_t              match;
  logic [IW-1:0]       exact_idx;
  logic [IW-1:0]       free_idx;

  logic [STATUS_W-1:0] dec_status;
  logic [ROUTER_W-1:0] dec_router;
  logic [PLEN_W-1:0]   dec_plen;
  logic                dec_we;
  logic [IW-1:0]       dec_addr;
  entry_t              dec_data;
  logic                rc_bad;

  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  entry_t              wr_data;

  assign rc = (9'(router_count) > 9'(LPR_MAX_ROUTERS)) ? RCOUNT_W'(LPR_MAX_ROUTERS)
                                                       : router_count;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign issue    = (state == ST_SCAN) && (cnt != CW'(TABLE_ENTRIES));
  assign can_out  = !m_tvalid || m_tready;
  assign finish   = (state == ST_DECIDE) && can_out;
  assign m_tdata  = {3'b000, out_plen, out_router, out_status};

  always_comb begin
    rc_bad     = ({1'b0, op_router} >= rc);
    dec_status = STATUS_OK;
    dec_router = '0;
    dec_plen   = '0;
    dec_we     = 1'b0;
    dec_addr   = free_idx;
    dec_data   = '{valid: 1'b1, address: op_address, owner: op_router};
    case (op_action)
      ACT_ADD: begin
        if (rc_bad) begin
          dec_status = STATUS_BAD_ROUTER;
        end else if (match.exact_hit) begin
          dec_status = STATUS_DUPLICATE;
        end else if (match.free_hit) begin
          dec_we = 1'b1;
        end else begin
          dec_status = STATUS_TABLE_FULL;
        end
      end
      ACT_DELETE: begin
        if (match.exact_hit) begin
          dec_router = match.exact_owner;
          dec_plen   = PLEN_FULL;
          dec_we     = 1'b1;
          dec_addr   = exact_idx;
          dec_data   = '{valid: 1'b0, address: op_address, owner: match.exact_owner};
        end else begin
          dec_status = STATUS_NOT_FOUND;
        end
      end
      ACT_LPM: begin
        if (rc_bad) begin
          dec_status = STATUS_BAD_ROUTER;
        end else if (!match.any) begin
          dec_status = STATUS_NO_DEVICES;
        end else begin
          dec_router = match.best_owner;
          dec_plen   = match.best_len;
          if (match.best_owner == op_router) begin
            dec_status = STATUS_SAME_ROUTER;
          end
        end
      end
      default: begin
        if (rc_bad) begin
          dec_status = STATUS_BAD_ROUTER;
        end else if (!match.exact_hit) begin
          dec_status = STATUS_NOT_FOUND;
        end else begin
          dec_router = match.exact_owner;
          dec_plen   = PLEN_FULL;
          if (match.exact_owner == op_router) begin
            dec_status = STATUS_SAME_ROUTER;
          end
        end
      end
    endcase
  end

  always_comb begin
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = cnt[IW-1:0];
      wr_data = '0;
    end else begin
      wr_en   = finish && dec_we;
      wr_addr = dec_addr;
      wr_data = dec_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      cnt          <= '0;
      chk_pending  <= 1'b0;
      m_tvalid     <= 1'b0;
      router_count <= RCOUNT_RESET;
    end else begin
      if (cfg_wr_en) begin
        router_count <= cfg_wr_data;
      end
      chk_pending <= issue;
      if (finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == CW'(TABLE_ENTRIES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cnt   <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            cnt <= cnt + 1'b1;
          end else if (!chk_pending) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (can_out) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    chk_idx <= cnt[IW-1:0];
    if (accept) begin
      op_action  <= s_tdata[1:0];
      op_address <= s_tdata[33:2];
      op_router  <= s_tdata[37:34];
    end
    if (finish) begin
      out_status <= dec_status;
      out_router <= dec_router;
      out_plen   <= dec_plen;
    end
  end

  lpr_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (issue),
    .rd_addr (cnt[IW-1:0]),
    .rd_data (rd_data)
  );

  lpr_match #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_match (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .chk_valid (chk_pending),
    .chk_idx   (chk_idx),
    .entry     (rd_data),
    .key       (op_address),
    .rc        (rc),
    .result    (match),
    .exact_idx (exact_idx),
    .free_idx  (free_idx)
  );

endmodule
